/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/lr_pkg.sv */
package lr_pkg;

	localparam int COORD_BITS = 11;
	localparam int DEC_BITS   = COORD_BITS + 3;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	typedef struct packed {
		logic   mode;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} in_item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   pixel_valid;
		logic   last_pixel;
	} out_item_t;

	// walker state
	typedef struct packed {
		coord_t cur_x;
		coord_t cur_y;
		dec_t   decision;
		dec_t   inc_axial;
		dec_t   inc_diagonal;
		coord_t steps_left;
		logic   y_major;
		logic   x_leftward;
		logic   active;
	} lr_state_t;

endpackage

/* hw/rtl/lr_setup.sv */
module lr_setup (
	input  lr_pkg::in_item_t  item,
	output lr_pkg::lr_state_t init
);

	lr_pkg::coord_t x0, y0, x1, y1;
	lr_pkg::coord_t adx, ady, major, minor;
	lr_pkg::dec_t   major_e, minor_e;
	logic           swap, left, ymaj;

	always_comb begin
		// orient so y never decreases
		swap = item.start_y > item.end_y;
		x0   = swap ? item.end_x   : item.start_x;
		y0   = swap ? item.end_y   : item.start_y;
		x1   = swap ? item.start_x : item.end_x;
		y1   = swap ? item.start_y : item.end_y;

		left  = x0 > x1;
		adx   = left ? (x0 - x1) : (x1 - x0);
		ady   = y1 - y0;
		ymaj  = ady > adx;
		major = ymaj ? ady : adx;
		minor = ymaj ? adx : ady;

		major_e = {{(lr_pkg::DEC_BITS-lr_pkg::COORD_BITS){1'b0}}, major};
		minor_e = {{(lr_pkg::DEC_BITS-lr_pkg::COORD_BITS){1'b0}}, minor};

		init.cur_x        = x0;
		init.cur_y        = y0;
		init.inc_axial    = minor_e <<< 1;
		init.inc_diagonal = (minor_e - major_e) <<< 1;
		init.decision     = (minor_e <<< 1) - major_e;
		init.steps_left   = major;
		init.y_major      = ymaj;
		init.x_leftward   = left;
		init.active       = major != '0;
	end

endmodule

/* hw/rtl/lr_step.sv */
module lr_step (
	input  lr_pkg::lr_state_t cur,
	output lr_pkg::lr_state_t nxt
);

	logic           axial, move_x, move_y;
	lr_pkg::coord_t left_steps;

	always_comb begin
		// ties take the axial move
		axial  = cur.decision[lr_pkg::DEC_BITS-1] || (cur.decision == '0);
		move_x = !axial || !cur.y_major;
		move_y = !axial || cur.y_major;
		left_steps = cur.steps_left - lr_pkg::coord_t'(1);

		nxt = cur;
		if (move_x) begin
			nxt.cur_x = cur.x_leftward ? (cur.cur_x - lr_pkg::coord_t'(1))
			                           : (cur.cur_x + lr_pkg::coord_t'(1));
		end
		if (move_y) begin
			nxt.cur_y = cur.cur_y + lr_pkg::coord_t'(1);
		end
		nxt.decision   = cur.decision + (axial ? cur.inc_axial : cur.inc_diagonal);
		nxt.steps_left = left_steps;
		nxt.active     = left_steps != '0;
	end

endmodule

/* hw/rtl/line_rasterizer.sv */
// Bresenham line rasterizer. A load transfer (mode 0) takes two endpoints,
// orders them so y never decreases, sets up the decision term and emits the
// first pixel; each step transfer (mode 1) emits the next pixel, and the far
// endpoint comes out with last_pixel set. A segment of major length M gives
// M+1 pixels: one load plus M steps. A step with no segment in progress gives
// a result with pixel_valid low and all other fields zero. Every input
// transfer yields exactly one result transfer. Throughput is one transfer per
// clock while the result side does not stall. An accepted item is held in the
// input register, then the setup or step logic loads the result register and
// updates the walker state in the same cycle. With the result register full and
// stalled, one further item is held in the input register before req_ready drops.

`include "assert_macros.svh"

module line_rasterizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lr_pkg::in_item_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lr_pkg::out_item_t rsp
);

	// input register stage
	logic              valid_s1;
	lr_pkg::in_item_t  item_s1;

	// walker state and result register
	lr_pkg::lr_state_t state_q;
	lr_pkg::out_item_t rsp_q;
	logic              rsp_valid_q;

	lr_pkg::lr_state_t init_state;
	lr_pkg::lr_state_t step_state;
	logic              advance;

	// segment setup from a load item
	lr_setup u_setup (
		.item (item_s1),
		.init (init_state)
	);

	// one pixel step of the walker
	lr_step u_step (
		.cur (state_q),
		.nxt (step_state)
	);

	// the input stage moves on when the result register is free or drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	// walker state, updated as an item enters the result register, unless it is a step with no segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			if (item_s1.mode == lr_pkg::MODE_LOAD) begin
				state_q <= init_state;
			end else if (state_q.active) begin
				state_q <= step_state;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (item_s1.mode == lr_pkg::MODE_LOAD) begin
				rsp_q.pixel_x     <= init_state.cur_x;
				rsp_q.pixel_y     <= init_state.cur_y;
				rsp_q.pixel_valid <= 1'b1;
				rsp_q.last_pixel  <= !init_state.active;
			end else if (state_q.active) begin
				rsp_q.pixel_x     <= step_state.cur_x;
				rsp_q.pixel_y     <= step_state.cur_y;
				rsp_q.pixel_valid <= 1'b1;
				rsp_q.last_pixel  <= !step_state.active;
			end else begin
				// step with no segment in progress
				rsp_q <= '0;
			end
		end
	end

	// a segment in progress always has pixels left, an idle walker none
	`ASSERT_SAME(a_active_steps, clk, arst_n, state_q.active, state_q.steps_left != '0)
	`ASSERT_SAME(a_idle_steps, clk, arst_n, !state_q.active, state_q.steps_left == '0)
	// a stalled result freezes the walker
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, rsp_valid_q && !rsp_ready, $stable(state_q))
	// a step without a segment yields an empty result
	`ASSERT_NEXT(a_idle_step, clk, arst_n,
		advance && (item_s1.mode == lr_pkg::MODE_STEP) && !state_q.active,
		!rsp_q.pixel_valid && !rsp_q.last_pixel)

endmodule

/* tb/tb.sv */
module tb;

	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 8;      // two-stage pipe, plus margin
	localparam int HOLD_CYCLES  = 60;     // long output back-pressure stretch
	localparam int HOLD_AFTER   = 300;    // pixels seen before that stretch starts
	localparam int DRAIN_AT     = 450;    // items sent before an input pause until the pipe is empty
	localparam int CMAX         = (1 << lr_pkg::COORD_BITS) - 1;

	typedef struct {
		lr_pkg::in_item_t  it;
		bit                lit_on;
		lr_pkg::out_item_t lit;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	lr_pkg::in_item_t  req;
	logic              rsp_valid;
	logic              rsp_ready;
	lr_pkg::out_item_t rsp;

	// expectation typed into the table, travels alongside req
	bit                want_lit;
	lr_pkg::out_item_t lit_pixel;

	lr_pkg::out_item_t pixel_q[$];
	row_t              dir_rows[$];
	int                mismatches;
	int                pixels_out;
	int                sent;
	int                cycles;
	bit                calm;
	bit                stall_on;

	// predicted walker state
	lr_pkg::coord_t w_x;
	lr_pkg::coord_t w_y;
	lr_pkg::dec_t   w_e;
	lr_pkg::dec_t   w_ax;
	lr_pkg::dec_t   w_dg;
	lr_pkg::coord_t w_steps;
	logic           w_ymaj;
	logic           w_left;
	logic           w_active;

	line_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// next pixel of the line for one accepted transfer, advancing the walker
	function automatic lr_pkg::out_item_t rasterize_pixel(lr_pkg::in_item_t it);
		lr_pkg::coord_t    x0, y0, x1, y1, t, adx, ady, major, minor;
		lr_pkg::out_item_t px;
		px = '0;
		if (it.mode == lr_pkg::MODE_LOAD) begin
			x0 = it.start_x;
			y0 = it.start_y;
			x1 = it.end_x;
			y1 = it.end_y;
			// downward segments get their endpoints swapped
			if (y0 > y1) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			w_left = x0 > x1;
			adx    = w_left ? x0 - x1 : x1 - x0;
			ady    = y1 - y0;
			w_ymaj = ady > adx;
			major  = w_ymaj ? ady : adx;
			minor  = w_ymaj ? adx : ady;
			w_ax     = lr_pkg::dec_t'(2 * int'(minor));
			w_dg     = lr_pkg::dec_t'(2 * int'(minor) - 2 * int'(major));
			w_e      = lr_pkg::dec_t'(2 * int'(minor) - int'(major));
			w_steps  = major;
			w_x      = x0;
			w_y      = y0;
			w_active = major != '0;
			px.pixel_x     = w_x;
			px.pixel_y     = w_y;
			px.pixel_valid = 1'b1;
			px.last_pixel  = !w_active;
		end else if (w_active) begin
			// ties take the axial move
			if (w_e <= 0) begin
				if (w_ymaj)
					w_y = w_y + 1'b1;
				else
					w_x = w_left ? w_x - 1'b1 : w_x + 1'b1;
				w_e = w_e + w_ax;
			end else begin
				w_x = w_left ? w_x - 1'b1 : w_x + 1'b1;
				w_y = w_y + 1'b1;
				w_e = w_e + w_dg;
			end
			w_steps = w_steps - 1'b1;
			if (w_steps == '0)
				w_active = 1'b0;
			px.pixel_x     = w_x;
			px.pixel_y     = w_y;
			px.pixel_valid = 1'b1;
			px.last_pixel  = !w_active;
		end
		return px;
	endfunction

	function automatic lr_pkg::coord_t clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > CMAX)
			return lr_pkg::coord_t'(CMAX);
		return lr_pkg::coord_t'(v);
	endfunction

	// idle length: mostly none, sometimes short, rarely long
	function automatic int pick_idle();
		int r;
		if (calm || stall_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void add_row(logic mode, int sx, int sy, int ex, int ey,
		int lit_on, int px, int py, int pv, int pl);
		row_t r;
		r.it.mode          = mode;
		r.it.start_x       = lr_pkg::coord_t'(sx);
		r.it.start_y       = lr_pkg::coord_t'(sy);
		r.it.end_x         = lr_pkg::coord_t'(ex);
		r.it.end_y         = lr_pkg::coord_t'(ey);
		r.lit_on           = 1'(lit_on);
		r.lit.pixel_x      = lr_pkg::coord_t'(px);
		r.lit.pixel_y      = lr_pkg::coord_t'(py);
		r.lit.pixel_valid  = 1'(pv);
		r.lit.last_pixel   = 1'(pl);
		dir_rows.push_back(r);
	endfunction

	task automatic flag_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// offer one request transfer and hold it until accepted
	task automatic send_item(lr_pkg::in_item_t it, bit lit_on, lr_pkg::out_item_t lit);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= it;
		want_lit  <= lit_on;
		lit_pixel <= lit;
		do @(posedge clk); while (!req_ready);
		sent++;
	endtask

	// step transfer with junk coordinates, which the block must ignore
	task automatic send_step();
		lr_pkg::in_item_t s;
		s      = lr_pkg::in_item_t'({$urandom, $urandom});
		s.mode = lr_pkg::MODE_STEP;
		send_item(s, 1'b0, '0);
	endtask

	// transfer monitor and scoreboard
	always @(posedge clk) begin
		lr_pkg::out_item_t predicted;
		lr_pkg::out_item_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predicted = rasterize_pixel(req);
				pixel_q.push_back(want_lit ? lit_pixel : predicted);
			end
			if (rsp_valid && rsp_ready) begin
				pixels_out++;
				if (pixel_q.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending (%0d,%0d v%0b l%0b)",
						rsp.pixel_x, rsp.pixel_y, rsp.pixel_valid, rsp.last_pixel));
				end else begin
					want = pixel_q.pop_front();
					if (rsp.pixel_x !== want.pixel_x)
						flag_mismatch($sformatf("pixel_x got %0d want %0d",
							rsp.pixel_x, want.pixel_x));
					if (rsp.pixel_y !== want.pixel_y)
						flag_mismatch($sformatf("pixel_y got %0d want %0d",
							rsp.pixel_y, want.pixel_y));
					if (rsp.pixel_valid !== want.pixel_valid)
						flag_mismatch($sformatf("pixel_valid got %b want %b",
							rsp.pixel_valid, want.pixel_valid));
					if (rsp.last_pixel !== want.last_pixel)
						flag_mismatch($sformatf("last_pixel got %b want %b",
							rsp.last_pixel, want.last_pixel));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// result side: random back-pressure, one long hold-off once the run is underway
	initial begin
		bit held;
		int n;
		held      = 1'b0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && pixels_out >= HOLD_AFTER) begin
				// input side keeps offering, so both pipe stages fill and req_ready drops
				held      = 1'b1;
				stall_on  = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_on  = 1'b0;
				rsp_ready <= 1'b1;
			end else begin
				n = pick_idle();
				if (n == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	// stimulus
	initial begin
		lr_pkg::in_item_t seg;
		int       kind, r, span, dx, dy, adx, ady, major, n, total;
		bit       drained;
		drained    = 1'b0;
		mismatches = 0;
		pixels_out = 0;
		sent       = 0;
		cycles     = 0;
		calm       = 1'b0;
		stall_on   = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		want_lit   = 1'b0;
		lit_pixel  = '0;
		arst_n     = 1'b0;

		// predicted walker starts out of reset with no segment
		w_x      = '0;
		w_y      = '0;
		w_e      = '0;
		w_ax     = '0;
		w_dg     = '0;
		w_steps  = '0;
		w_ymaj   = 1'b0;
		w_left   = 1'b0;
		w_active = 1'b0;

		// step with nothing loaded, single-pixel segments at both corners
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_LOAD, 0, 0, 0, 0, 1, 0, 0, 1, 1);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_LOAD, CMAX, CMAX, CMAX, CMAX, 1, CMAX, CMAX, 1, 1);
		add_row(lr_pkg::MODE_STEP, CMAX, CMAX, CMAX, CMAX, 1, 0, 0, 0, 0);
		// full-width horizontal, a few pixels, then abandoned
		add_row(lr_pkg::MODE_LOAD, 0, 0, CMAX, 0, 1, 0, 0, 1, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, CMAX, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// downward segment gets swapped, loaded over the active one
		add_row(lr_pkg::MODE_LOAD, 5, CMAX, CMAX, 0, 1, CMAX, 0, 1, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// steep segment run to its end, then a step past it
		add_row(lr_pkg::MODE_LOAD, 0, 0, 1, 3, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		// decision term starts at zero, tie goes axial
		add_row(lr_pkg::MODE_LOAD, 0, 0, 2, 1, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// vertical full height, swapped
		add_row(lr_pkg::MODE_LOAD, 0, CMAX, 0, 0, 1, 0, 0, 1, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// full anti-diagonal, x leftward
		add_row(lr_pkg::MODE_LOAD, CMAX, 0, 0, CMAX, 1, CMAX, 0, 1, 0);
		add_row(lr_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);

		total = dir_rows.size() + RANDOM_ITEMS;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].lit_on, dir_rows[i].lit);

		while (sent < total) begin
			calm = ($urandom_range(0, 5) == 0);
			if (!drained && sent >= DRAIN_AT) begin
				// input pause until every pending pixel has come out
				drained = 1'b1;
				@(negedge clk);
				req_valid <= 1'b0;
				while (pixel_q.size() != 0) @(negedge clk);
			end
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				// well-formed segment, mostly short, anywhere on the grid
				r = $urandom_range(0, 99);
				if (r < 90)
					span = $urandom_range(0, 12);
				else if (r < 98)
					span = 64;
				else
					span = 300;
				dx = $urandom_range(0, 2 * span) - span;
				dy = $urandom_range(0, 2 * span) - span;
				seg.mode    = lr_pkg::MODE_LOAD;
				seg.start_x = lr_pkg::coord_t'($urandom_range(0, CMAX));
				seg.start_y = lr_pkg::coord_t'($urandom_range(0, CMAX));
				seg.end_x   = clamp_coord(int'(seg.start_x) + dx);
				seg.end_y   = clamp_coord(int'(seg.start_y) + dy);
				send_item(seg, 1'b0, '0);
				adx = int'(seg.end_x) - int'(seg.start_x);
				ady = int'(seg.end_y) - int'(seg.start_y);
				if (adx < 0)
					adx = -adx;
				if (ady < 0)
					ady = -ady;
				major = (adx > ady) ? adx : ady;
				// usually walk to the end, sometimes cut short or run past it
				n = major;
				r = $urandom_range(0, 99);
				if (r < 15 && major > 0)
					n = $urandom_range(0, major - 1);
				else if (r < 30)
					n = major + $urandom_range(1, 3);
				// keep the run near its item count
				if (n > total - sent)
					n = total - sent;
				repeat (n) send_step();
			end else if (kind < 93) begin
				// fully random endpoints, only a few steps
				seg      = lr_pkg::in_item_t'({$urandom, $urandom});
				seg.mode = lr_pkg::MODE_LOAD;
				send_item(seg, 1'b0, '0);
				repeat ($urandom_range(0, 3)) send_step();
			end else begin
				repeat ($urandom_range(1, 3)) send_step();
			end
		end
		calm = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		while (pixel_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_setup.sv
hw/rtl/lr_step.sv
hw/rtl/line_rasterizer.sv
tb/tb.sv
